### hdl/sadc_pkg.sv
// ----------------------------------------------------------------------------
// Serial ADC scanner package
// Shared types, constants and helpers for the scan controller and its
// channel statistics store.
// ----------------------------------------------------------------------------
package sadc_pkg;

    // Sample word and field widths.
    localparam int SAMPLE_BITS   = 10;
    localparam int CH_W          = 4;
    localparam int LIST_W        = 44;
    localparam int COUNT_W       = 4;
    localparam int SETTLE_W      = 16;
    localparam int HALF_W        = 8;
    localparam int CFG_W         = 44;
    localparam int CFG_IDX_W     = 2;
    localparam int IN_DATA_W     = 8;
    localparam int OUT_DATA_W    = 40;
    localparam int ADDR_SHIFT_W  = 8;

    // Defaults for the top-level parameters.
    localparam int DEF_CHANNELS  = 11;
    localparam int DEF_MAX_SLOTS = 11;

    // Register reset values.
    localparam logic [LIST_W-1:0]   RST_CHAN_LIST = LIST_W'(44'hA43210);
    localparam logic [COUNT_W-1:0]  RST_COUNT     = COUNT_W'(6);
    localparam logic [SETTLE_W-1:0] RST_SETTLE    = SETTLE_W'(50);
    localparam logic [HALF_W-1:0]   RST_HALF      = HALF_W'(1);

    // Command codes carried in the input tuser.
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CHAN_LIST = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HALF      = 2'd3;

    // Sequencer phases, one-hot.
    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_LOW    = 4'b0010,
        PH_HIGH   = 4'b0100,
        PH_SETTLE = 4'b1000
    } phase_t;

    // Configuration register set.
    typedef struct packed {
        logic [LIST_W-1:0]   chan_list;
        logic [COUNT_W-1:0]  count;
        logic [SETTLE_W-1:0] settle;
        logic [HALF_W-1:0]   half;
    } cfg_t;

    // Store and query request from the sequencer to the statistics store.
    typedef struct packed {
        logic                   store_en;
        logic [CH_W-1:0]        store_ch;
        logic [SAMPLE_BITS-1:0] sample;
        logic                   query_en;
        logic [CH_W-1:0]        query_ch;
    } stat_req_t;

    // Pin levels after one step.
    typedef struct packed {
        logic busy;
        logic addr_bit;
        logic sclk;
        logic cs_n;
    } pins_t;

    // One statistics entry.
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] max_val;
        logic [SAMPLE_BITS-1:0] min_val;
        logic [SAMPLE_BITS-1:0] value;
    } stat_word_t;

    localparam stat_word_t STAT_RESET = '{
        max_val: '0,
        min_val: '1,
        value:   '0
    };

    // Channel number held in one slot of the packed channel list.
    function automatic logic [CH_W-1:0] chan_of(input logic [LIST_W-1:0] list,
                                                input logic [3:0] slot);
        logic [63:0] padded;
        padded = {{(64-LIST_W){1'b0}}, list};
        return padded[{slot, 2'b00} +: CH_W];
    endfunction

endpackage

### hdl/serial_adc_scanner_min_max_unit.sv
// ----------------------------------------------------------------------------
// Serial ADC scanner with per-channel minimum and maximum
// Drives a 10-bit serial converter through a scan of configured channel
// slots and keeps the latest, smallest and largest sample of each channel.
//
//   Channel  Direction  Carries
//   s_axis   in         tuser: command; tdata: dout_bit, query_channel
//   m_axis   out        tdata: pin levels, busy, value, min, max
//   cfg      in         write enable, register index, register data
//
// One item per clock cycle when the output side keeps up; each result item
// goes through the update stage, then the output register (sequencer step
// and memory read at the accepting edge, update and output register when it
// advances). The statistics memory is read on accept, written back on that
// advance; a read meeting that write on the same edge takes the forwarded word.
// Reset idles the sequencer and marks every channel unwritten at once, so
// entries read as value 0, minimum 1023, maximum 0 with no clearing pass.
// A stalled output holds its item and one more in the update stage.
// ----------------------------------------------------------------------------
module serial_adc_scanner_min_max_unit
    import sadc_pkg::*;
#(
    parameter int CHANNELS  = DEF_CHANNELS,
    parameter int MAX_SLOTS = DEF_MAX_SLOTS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Input items.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // dout_bit[0], query_channel[4:1]
    input  logic [1:0]            s_axis_tuser,   // command[1:0]
    // Result items.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // chip_select_n[0], serial_clock[1],
                                                  // address_bit[2], busy_res[3],
                                                  // channel_value[13:4],
                                                  // channel_min[23:14],
                                                  // channel_max[33:24]
    // Configuration writes.
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    cfg_t                   cfg_reg;
    stat_req_t              req;
    pins_t                  pins;
    pins_t                  s1_pins_reg;
    logic                   s1_valid_reg;
    logic                   out_valid_reg;
    logic [OUT_DATA_W-1:0]  out_data_reg;
    stat_word_t             result;
    logic                   accept;
    logic                   adv;

    // Handshake and pipeline advance.
    assign adv           = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || adv;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.chan_list <= RST_CHAN_LIST;
            cfg_reg.count     <= RST_COUNT;
            cfg_reg.settle    <= RST_SETTLE;
            cfg_reg.half      <= RST_HALF;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_CHAN_LIST: cfg_reg.chan_list <= cfg_data[LIST_W-1:0];
                REG_COUNT:     cfg_reg.count     <= cfg_data[COUNT_W-1:0];
                REG_SETTLE:    cfg_reg.settle    <= cfg_data[SETTLE_W-1:0];
                REG_HALF:      cfg_reg.half      <= cfg_data[HALF_W-1:0];
                default:       cfg_reg           <= cfg_reg;
            endcase
        end
    end

    // Pin sequencer.
    sadc_seq #(
        .CHANNELS  (CHANNELS),
        .MAX_SLOTS (MAX_SLOTS)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .step_en       (accept),
        .command       (s_axis_tuser),
        .dout_bit      (s_axis_tdata[0]),
        .query_channel (s_axis_tdata[CH_W:1]),
        .cfg           (cfg_reg),
        .req           (req),
        .pins          (pins)
    );

    // Statistics memory.
    sadc_stat #(
        .CHANNELS (CHANNELS)
    ) u_stat (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_en  (accept),
        .req    (req),
        .wr_adv (adv),
        .result (result)
    );

    // Update stage: pin levels wait beside the memory read.
    always_ff @(posedge clk)
    begin
        if (accept)
            s1_pins_reg <= pins;
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (adv)
            out_data_reg <= {{(OUT_DATA_W - 4 - 3*SAMPLE_BITS){1'b0}},
                             result.max_val, result.min_val, result.value,
                             s1_pins_reg.busy, s1_pins_reg.addr_bit,
                             s1_pins_reg.sclk, s1_pins_reg.cs_n};
    end

    // Stage occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (adv)
                s1_valid_reg <= 1'b0;

            if (adv)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef NO_ASSERTIONS
    // An accepted item always lands in the update stage.
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted item did not reach the update stage");

    // An advancing item always lands in the output register.
    a_adv_fills: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> out_valid_reg)
        else $error("advancing item did not reach the output register");

    // Chip select is low exactly while busy.
    a_cs_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg[0] != out_data_reg[3]))
        else $error("chip select and busy disagree");

    // Minimum above maximum only for a never-written channel.
    a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_data_reg[23:14] > out_data_reg[33:24]))
        |-> ((out_data_reg[13:4] == '0) && (out_data_reg[23:14] == '1)
             && (out_data_reg[33:24] == '0)))
        else $error("inconsistent channel statistics");
`endif

endmodule

### hdl/sadc_seq.sv
// ----------------------------------------------------------------------------
// Serial ADC scan sequencer
// Runs one tick of the pin sequencer per item: chip select, serial clock,
// address shift-out and data shift-in, and raises store and query requests.
// ----------------------------------------------------------------------------
module sadc_seq
    import sadc_pkg::*;
#(
    parameter int CHANNELS  = DEF_CHANNELS,
    parameter int MAX_SLOTS = DEF_MAX_SLOTS
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step_en,
    input  logic [1:0]      command,
    input  logic            dout_bit,
    input  logic [CH_W-1:0] query_channel,
    input  cfg_t            cfg,
    output stat_req_t       req,
    output pins_t           pins
);

    phase_t                    phase_reg, phase_next;
    logic [3:0]                bit_count_reg, bit_count_next;
    logic [3:0]                slot_index_reg, slot_index_next;
    logic [SAMPLE_BITS-1:0]    shift_in_reg, shift_in_next;
    logic [ADDR_SHIFT_W-1:0]   address_shift_reg, address_shift_next;
    logic [SETTLE_W-1:0]       wait_count_reg, wait_count_next;

    logic [4:0]                slot_total;
    logic [HALF_W-1:0]         half_len;
    logic [4:0]                slot_inc;
    logic                      last_slot;
    logic                      start_now;
    logic [3:0]                begin_slot;
    logic [4:0]                begin_inc;
    logic [3:0]                begin_peer;
    logic [4:0]                bit_inc;
    logic                      do_begin;
    logic                      store_hit;
    logic [CH_W-1:0]           store_ch;
    logic                      wait_more;

    // Clamped slot count and half period.
    always_comb
    begin
        if (cfg.count == '0)
            slot_total = 5'd1;
        else if ({1'b0, cfg.count} > 5'(MAX_SLOTS))
            slot_total = 5'(MAX_SLOTS);
        else
            slot_total = {1'b0, cfg.count};
        half_len = (cfg.half == '0) ? HALF_W'(1) : cfg.half;
    end

    // Slot bookkeeping for ending a slot and starting the next one.
    assign slot_inc   = {1'b0, slot_index_reg} + 5'd1;
    assign last_slot  = (slot_inc >= slot_total);
    assign start_now  = (command == CMD_START) && (phase_reg == PH_IDLE);
    assign begin_slot = start_now ? 4'd0 : slot_inc[3:0];
    assign begin_inc  = {1'b0, begin_slot} + 5'd1;
    assign begin_peer = (begin_inc >= slot_total) ? 4'd0 : begin_inc[3:0];
    assign bit_inc    = {1'b0, bit_count_reg} + 5'd1;
    assign wait_more  = (wait_count_reg > SETTLE_W'(1));

    // One sequencer tick.
    always_comb
    begin
        phase_next         = phase_reg;
        bit_count_next     = bit_count_reg;
        slot_index_next    = slot_index_reg;
        shift_in_next      = shift_in_reg;
        address_shift_next = address_shift_reg;
        wait_count_next    = wait_count_reg;
        do_begin           = 1'b0;
        store_hit          = 1'b0;

        if (start_now)
        begin
            do_begin = 1'b1;
        end
        else
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                end
                PH_LOW:
                begin
                    if (wait_more)
                        wait_count_next = wait_count_reg - SETTLE_W'(1);
                    else
                    begin
                        shift_in_next   = {shift_in_reg[SAMPLE_BITS-2:0], dout_bit};
                        phase_next      = PH_HIGH;
                        wait_count_next = SETTLE_W'(half_len);
                    end
                end
                PH_HIGH:
                begin
                    if (wait_more)
                        wait_count_next = wait_count_reg - SETTLE_W'(1);
                    else
                    begin
                        address_shift_next = {address_shift_reg[ADDR_SHIFT_W-2:0], 1'b0};
                        bit_count_next     = bit_inc[3:0];
                        if (bit_inc >= 5'(SAMPLE_BITS))
                        begin
                            store_hit = 1'b1;
                            if (cfg.settle == '0)
                            begin
                                if (last_slot)
                                    phase_next = PH_IDLE;
                                else
                                    do_begin = 1'b1;
                            end
                            else
                            begin
                                phase_next      = PH_SETTLE;
                                wait_count_next = cfg.settle;
                            end
                        end
                        else
                        begin
                            phase_next      = PH_LOW;
                            wait_count_next = SETTLE_W'(half_len);
                        end
                    end
                end
                PH_SETTLE:
                begin
                    if (wait_more)
                        wait_count_next = wait_count_reg - SETTLE_W'(1);
                    else if (last_slot)
                        phase_next = PH_IDLE;
                    else
                        do_begin = 1'b1;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        // Set up the first clock-low phase of a slot.
        if (do_begin)
        begin
            slot_index_next    = begin_slot;
            bit_count_next     = 4'd0;
            shift_in_next      = '0;
            address_shift_next = {chan_of(cfg.chan_list, begin_peer), 4'b0000};
            phase_next         = PH_LOW;
            wait_count_next    = SETTLE_W'(half_len);
        end
    end

    // Requests for the statistics store.
    assign store_ch = chan_of(cfg.chan_list, slot_index_reg);

    always_comb
    begin
        req.store_en = store_hit && ({1'b0, store_ch} < 5'(CHANNELS));
        req.store_ch = store_ch;
        req.sample   = shift_in_reg;
        req.query_en = (command == CMD_READ) && ({1'b0, query_channel} < 5'(CHANNELS));
        req.query_ch = query_channel;
    end

    // Pin levels after this tick.
    always_comb
    begin
        pins.busy     = (phase_next != PH_IDLE);
        pins.cs_n     = (phase_next == PH_IDLE);
        pins.sclk     = (phase_next == PH_HIGH);
        pins.addr_bit = (phase_next != PH_IDLE) && address_shift_next[ADDR_SHIFT_W-1];
    end

    // Sequencer state advances once per accepted item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            bit_count_reg     <= '0;
            slot_index_reg    <= '0;
            shift_in_reg      <= '0;
            address_shift_reg <= '0;
            wait_count_reg    <= '0;
        end
        else if (step_en)
        begin
            phase_reg         <= phase_next;
            bit_count_reg     <= bit_count_next;
            slot_index_reg    <= slot_index_next;
            shift_in_reg      <= shift_in_next;
            address_shift_reg <= address_shift_next;
            wait_count_reg    <= wait_count_next;
        end
    end

endmodule

### hdl/sadc_stat.sv
// ----------------------------------------------------------------------------
// Serial ADC channel statistics store
// One synchronous memory of value, minimum and maximum per channel, read at
// the store channel and the query channel, updated when the item advances.
// ----------------------------------------------------------------------------
module sadc_stat
    import sadc_pkg::*;
#(
    parameter int CHANNELS = DEF_CHANNELS
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rd_en,
    input  stat_req_t  req,
    input  logic       wr_adv,
    output stat_word_t result
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    stat_word_t             stat_mem [CHANNELS];
    logic [CHANNELS-1:0]    valid_reg;

    logic [AW-1:0]          idx_a, idx_b;
    logic [AW-1:0]          idx_a_reg;
    stat_req_t              req_reg;
    stat_word_t             rd_a_reg, rd_b_reg;
    logic                   va_reg, vb_reg;
    logic                   fwd_a_reg, fwd_b_reg;
    stat_word_t             wr_word_reg;

    stat_word_t             entry_a, entry_b;
    stat_word_t             new_word;
    logic                   wr_en;

    // Read addresses; out-of-range channels never reach the memory.
    assign idx_a = req.store_en ? req.store_ch[AW-1:0] : '0;
    assign idx_b = req.query_en ? req.query_ch[AW-1:0] : '0;
    assign wr_en = wr_adv && req_reg.store_en;

    // Memory: two registered reads on accept, one write on advance.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_a_reg  <= stat_mem[idx_a];
            rd_b_reg  <= stat_mem[idx_b];
            req_reg   <= req;
            idx_a_reg <= idx_a;
        end
        if (wr_en)
        begin
            stat_mem[idx_a_reg] <= new_word;
            wr_word_reg         <= new_word;
        end
    end

    // Written-entry flags and forwarding of a write on the same edge as a read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            va_reg    <= 1'b0;
            vb_reg    <= 1'b0;
            fwd_a_reg <= 1'b0;
            fwd_b_reg <= 1'b0;
        end
        else
        begin
            if (rd_en)
            begin
                va_reg    <= valid_reg[idx_a];
                vb_reg    <= valid_reg[idx_b];
                fwd_a_reg <= wr_en && (idx_a_reg == idx_a);
                fwd_b_reg <= wr_en && (idx_a_reg == idx_b);
            end
            if (wr_en)
                valid_reg[idx_a_reg] <= 1'b1;
        end
    end

    // Current entries, seen through forwarding and the reset value.
    always_comb
    begin
        if (fwd_a_reg)
            entry_a = wr_word_reg;
        else if (va_reg)
            entry_a = rd_a_reg;
        else
            entry_a = STAT_RESET;

        if (fwd_b_reg)
            entry_b = wr_word_reg;
        else if (vb_reg)
            entry_b = rd_b_reg;
        else
            entry_b = STAT_RESET;
    end

    // Update of the stored channel.
    always_comb
    begin
        new_word.value   = req_reg.sample;
        new_word.min_val = (req_reg.sample < entry_a.min_val) ? req_reg.sample
                                                              : entry_a.min_val;
        new_word.max_val = (req_reg.sample > entry_a.max_val) ? req_reg.sample
                                                              : entry_a.max_val;
    end

    // Query result sees the store made by the same item.
    always_comb
    begin
        if (!req_reg.query_en)
            result = '0;
        else if (req_reg.store_en && (req_reg.query_ch == req_reg.store_ch))
            result = new_word;
        else
            result = entry_b;
    end

endmodule
